// File: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the Miller-Rabin prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int PROD_WIDTH = 2 * NUM_WIDTH;
	localparam int CNT_WIDTH = $clog2(PROD_WIDTH + 1);

	typedef logic [NUM_WIDTH-1:0] num_t;

	// modular multiply request / status
	typedef struct packed {
		logic start;
		num_t x;
		num_t y;
		num_t m;
	} mm_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		num_t r;
	} mm_rsp_t;

endpackage

`default_nettype wire

// File: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Multi-cycle (x*y) mod m: one registered 32x32 product, then restoring
// reduction, one remainder bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_mulmod
	import mrpt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  mm_req_t      req,
	output mm_rsp_t      rsp
);

	typedef enum logic [2:0] {
		MM_IDLE = 3'b001,
		MM_MUL  = 3'b010,
		MM_RED  = 3'b100
	} mm_state_t;

	mm_state_t state_q;
	logic [PROD_WIDTH-1:0] prod_q;
	logic [NUM_WIDTH:0]    rem_q;
	num_t                  x_q, y_q, m_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  done_q;

	logic [NUM_WIDTH:0] shifted;
	logic [NUM_WIDTH:0] diff;

	assign shifted = {rem_q[NUM_WIDTH-1:0], prod_q[PROD_WIDTH-1]};
	assign diff = shifted - {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MM_IDLE: begin
					if (req.start) begin
						state_q <= MM_MUL;
					end
				end
				MM_MUL: begin
					cnt_q   <= CNT_WIDTH'(PROD_WIDTH);
					state_q <= MM_RED;
				end
				MM_RED: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_WIDTH'(1)) begin
						state_q <= MM_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MM_IDLE && req.start) begin
			x_q <= req.x;
			y_q <= req.y;
			m_q <= req.m;
		end
		if (state_q == MM_MUL) begin
			prod_q <= PROD_WIDTH'(x_q) * PROD_WIDTH'(y_q);
			rem_q  <= '0;
		end
		if (state_q == MM_RED) begin
			prod_q <= {prod_q[PROD_WIDTH-2:0], 1'b0};
			rem_q  <= diff[NUM_WIDTH] ? shifted : diff;
		end
	end

	assign rsp.busy = (state_q != MM_IDLE);
	assign rsp.done = done_q;
	assign rsp.r    = rem_q[NUM_WIDTH-1:0];

endmodule

`default_nettype wire

// File: src/miller_rabin_prime_test_32.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_32
// Deterministic Miller-Rabin primality tester for 32-bit candidates.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis_*: one candidate per item in tdata. Accepted when tvalid and
//    tready are high; tready is high only while the sequencer is idle.
//  - m_axis_*: one prime flag item per candidate, held in an output register
//    until tready. The core may take the next candidate while a result waits;
//    it then holds its finished flag until the output register frees.
//  - Bases 2, 7 and 61 are tried in turn. Each base first finds n mod base
//    (one modular operation), splits n-1 into d*2^s (one shift per cycle),
//    runs square-and-multiply over the bits of d, then up to s squarings.
//  - Every modular operation goes through the single mulmod unit: issue, a
//    registered multiply, reduction over the 64 product bits, done.
//  - Work: at most 63 modular operations per base. A candidate with a
//    factor 2, 7 or 61 ends with the n mod base operation of the base that
//    finds it; 0, 1, 2, 7 and 61 skip the bases and go from the check
//    state to the output register.
//  - One candidate at a time: the next is taken once the sequencer is idle.
//  - Reset clears the sequencer and output valid; a stalled receiver holds
//    the result and, once the next flag is ready, keeps input tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test_32
	import mrpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] candidate
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // [0] prime_flag, [7:1] zero
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CHECK = 11'b00000000010,
		ST_DIV   = 11'b00000000100,
		ST_DIVW  = 11'b00000001000,
		ST_SPLIT = 11'b00000010000,
		ST_PSTEP = 11'b00000100000,
		ST_PWAIT = 11'b00001000000,
		ST_SQ    = 11'b00010000000,
		ST_SQW   = 11'b00100000000,
		ST_NEXT  = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	localparam num_t BASE0 = NUM_WIDTH'(2);
	localparam num_t BASE1 = NUM_WIDTH'(7);
	localparam num_t BASE2 = NUM_WIDTH'(61);
	localparam int SW = $clog2(NUM_WIDTH + 1);

	state_t state_q;
	num_t n_q, d_q, acc_q, pw_q, x_q;
	logic [1:0] bidx_q;
	logic [SW-1:0] s_q, r_q;
	logic pmul_q;     // 1: acc*pw pending, 0: pw*pw pending
	logic flag_q;     // finished flag of the core
	logic out_flag_q;
	logic out_valid_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	mrpt_mulmod u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.rsp   (mm_rsp)
	);

	num_t nm1;
	assign nm1 = n_q - 1'b1;

	num_t base_sel;
	always_comb begin
		unique case (bidx_q)
			2'd0:    base_sel = BASE0;
			2'd1:    base_sel = BASE1;
			default: base_sel = BASE2;
		endcase
	end

	// base passes: a^d == 1 before any squaring, or n-1 seen within s values
	logic more_sq;
	logic pass_now;
	assign more_sq  = (r_q < s_q);
	assign pass_now = (r_q == '0 && x_q == NUM_WIDTH'(1)) || (more_sq && x_q == nm1);

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		mm_req = '0;
		mm_req.m = n_q;
		unique case (state_q)
			ST_DIV: begin
				// n * 1 mod base
				mm_req.start = 1'b1;
				mm_req.x = n_q;
				mm_req.y = NUM_WIDTH'(1);
				mm_req.m = base_sel;
			end
			ST_PSTEP: begin
				mm_req.start = 1'b1;
				mm_req.x = pmul_q ? acc_q : pw_q;
				mm_req.y = pw_q;
			end
			ST_SQ: begin
				mm_req.start = 1'b1;
				mm_req.x = x_q;
				mm_req.y = x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			d_q     <= '0;
			acc_q   <= '0;
			pw_q    <= '0;
			x_q     <= '0;
			bidx_q  <= '0;
			s_q     <= '0;
			r_q     <= '0;
			pmul_q  <= 1'b0;
			flag_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						n_q     <= s_axis_tdata[NUM_WIDTH-1:0];
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					priority if (n_q < NUM_WIDTH'(2)) begin
						flag_q  <= 1'b0;
						state_q <= ST_OUT;
					end else if (n_q == BASE0 || n_q == BASE1 || n_q == BASE2) begin
						flag_q  <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						bidx_q  <= 2'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (mm_rsp.done) begin
						if (mm_rsp.r == '0) begin
							// divisible by the base and not equal to it
							flag_q  <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							d_q     <= nm1;
							s_q     <= '0;
							state_q <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: begin
					// n is odd and above 2 here, so n-1 is even and nonzero
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						acc_q   <= NUM_WIDTH'(1);
						pw_q    <= base_sel;
						pmul_q  <= 1'b1;
						state_q <= ST_PSTEP;
					end
				end
				ST_PSTEP: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (mm_rsp.done) begin
						if (pmul_q) begin
							if (d_q[NUM_WIDTH-1:1] == '0) begin
								// top bit of d: power done
								x_q     <= mm_rsp.r;
								r_q     <= '0;
								state_q <= ST_NEXT;
							end else begin
								acc_q   <= mm_rsp.r;
								pmul_q  <= 1'b0;
								state_q <= ST_PSTEP;
							end
						end else begin
							pw_q    <= mm_rsp.r;
							d_q     <= d_q >> 1;
							pmul_q  <= d_q[1];
							state_q <= ST_PSTEP;
						end
					end
				end
				ST_SQ: begin
					state_q <= ST_SQW;
				end
				ST_SQW: begin
					if (mm_rsp.done) begin
						x_q     <= mm_rsp.r;
						r_q     <= r_q + 1'b1;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					priority if (pass_now) begin
						if (bidx_q == 2'd2) begin
							flag_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							bidx_q  <= bidx_q + 1'b1;
							state_q <= ST_DIV;
						end
					end else if (more_sq) begin
						state_q <= ST_SQ;
					end else begin
						flag_q  <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_flag_q  <= flag_q;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_flag_q};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tdata[7:1] == 7'd0);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> !mm_rsp.busy);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 32-bit Miller-Rabin prime tester. Candidates
// are streamed in with random gaps; an internal predictor computes the
// expected prime flag and a monitor checks each result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] candidate
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [0] prime_flag, [7:1] zero

	// expected prime flags, oldest first
	bit          flag_queue[$];
	int          error_count = 0;

	miller_rabin_prime_test_32 DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y,
			logic [63:0] m);
		return (x * y) % m;
	endfunction

	function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = mod_mul(acc, b, m);
			b = mod_mul(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit base_passes(logic [63:0] n, logic [63:0] a);
		logic [63:0] d;
		logic [63:0] x;
		int twos;
		twos = 0;
		if (n % a == 0) return 1'b0;
		d = n - 64'd1;
		while (d != 0 && d[0] == 1'b0) begin
			d = d >> 1;
			twos++;
		end
		x = mod_pow(a, d, n);
		if (x == 1) return 1'b1;
		for (int r = 0; r < twos; r++) begin
			if (x == n - 64'd1) return 1'b1;
			x = mod_mul(x, x, n);
		end
		return 1'b0;
	endfunction

	function automatic bit model_prime(logic [31:0] cand);
		logic [63:0] n;
		n = {32'd0, cand};
		if (n < 2) return 1'b0;
		if (n == 2 || n == 7 || n == 61) return 1'b1;
		return base_passes(n, 64'd2) && base_passes(n, 64'd7) &&
			base_passes(n, 64'd61);
	endfunction

	// ---------------------------------------------------------------- driver
	// tvalid stays high after the handshake until the next call or a drain
	task automatic send_candidate(logic [31:0] cand);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cand;
		flag_queue = {flag_queue, model_prime(cand)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// receiver stall: new draw per item
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (flag_queue.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h",
					$time, m_axis_tdata);
				error_count++;
			end else begin
				bit exp_flag;
				exp_flag = flag_queue.pop_front();
				if (m_axis_tdata !== {7'd0, exp_flag}) begin
					$display("%0t: mismatch, expected %h, actual %h",
						$time, {7'd0, exp_flag}, m_axis_tdata);
					error_count++;
				end
			end
		end
	end

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (flag_queue.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_special_values();
		logic [31:0] vals[$];
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd61, 32'd14,
			32'd49, 32'd122, 32'd3721, 32'd5, 32'd9, 32'd25326001,
			32'd3215031751, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hAAAA_AAAB, 32'h5555_5555, 32'd4294967291};
		foreach (vals[i]) send_candidate(vals[i]);
	endtask

	// pause until every result is back, then resume
	task automatic test_drain_pause();
		wait_drained();
		send_candidate(32'd65537);
		send_candidate(32'd65535);
	endtask

	task automatic test_random_candidates();
		logic [31:0] cand;
		for (int i = 0; i < 80; i++) begin
			case ($urandom_range(0, 3))
				0: cand = $urandom();
				1: cand = $urandom() | 32'h1;            // odd, full width
				2: cand = $urandom_range(0, 1000);       // small, fast
				default: cand = ($urandom() & 32'hFFFF) | 32'h1;
			endcase
			send_candidate(cand);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_drain_pause();
		test_random_candidates();
		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog: 104 items in all; the limit allows far more time than they need
	initial begin
		#80ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
